@@ src/mcg_pkg.sv @@
package mcg_pkg;

	localparam int KIND_W   = 2;
	localparam int VID_W    = 10;
	localparam int WEIGHT_W = 24;
	localparam int GAIN_W   = 40;
	localparam int CUT_W    = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD,
		KIND_EDGE,
		KIND_FLIP,
		KIND_NBR
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDB,
		ST_CAPB,
		ST_WRA,
		ST_WRB,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic accept;
		logic cap_a;
		logic cap_b;
		logic wr_a;
		logic wr_b;
		logic load_out;
	} cmd_t;

	function automatic logic signed [GAIN_W-1:0] sat_gain(input logic signed [GAIN_W:0] v);
		logic signed [GAIN_W-1:0] r;
		if (v[GAIN_W] != v[GAIN_W-1]) begin
			r = v[GAIN_W] ? {1'b1, {(GAIN_W-1){1'b0}}} : {1'b0, {(GAIN_W-1){1'b1}}};
		end else begin
			r = v[GAIN_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [CUT_W-1:0] sat_cut(input logic signed [CUT_W:0] v);
		logic signed [CUT_W-1:0] r;
		if (v[CUT_W] != v[CUT_W-1]) begin
			r = v[CUT_W] ? {1'b1, {(CUT_W-1){1'b0}}} : {1'b0, {(CUT_W-1){1'b1}}};
		end else begin
			r = v[CUT_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ src/mcg_ctrl.sv @@
module mcg_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output mcg_pkg::cmd_t cmd
);
	import mcg_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RDB;
			ST_RDB:  state_d = ST_CAPB;
			ST_CAPB: state_d = ST_WRA;
			ST_WRA:  state_d = ST_WRB;
			ST_WRB:  state_d = ST_FIN;
			ST_FIN:  if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RDB:  cmd.cap_a = 1'b1;
			ST_CAPB: cmd.cap_b = 1'b1;
			ST_WRA:  cmd.wr_a = 1'b1;
			ST_WRB:  cmd.wr_b = 1'b1;
			ST_FIN:  cmd.load_out = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/mcg_datapath.sv @@
module mcg_datapath #(
	parameter int VERTICES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mcg_pkg::cmd_t                         cmd,
	input  logic [mcg_pkg::KIND_W-1:0]            kind,
	input  logic [mcg_pkg::VID_W-1:0]             vertex_a,
	input  logic [mcg_pkg::VID_W-1:0]             vertex_b,
	input  logic signed [mcg_pkg::WEIGHT_W-1:0]   edge_weight,
	input  logic                                  side,
	output logic signed [mcg_pkg::CUT_W-1:0]      cut_value,
	output logic signed [mcg_pkg::GAIN_W-1:0]     vertex_gain,
	output logic                                  vertex_side
);
	import mcg_pkg::*;

	localparam int AW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

	logic [GAIN_W:0] mem [VERTICES];
	logic [GAIN_W:0] rdata_q;
	logic [GAIN_W:0] wdata;
	logic [AW-1:0]   addr;
	logic            we;

	kind_t                      kind_q;
	logic [VID_W-1:0]           a_q, b_q;
	logic signed [WEIGHT_W-1:0] w_q;
	logic                       s_q;
	logic                       sa_q, sb_q;
	logic signed [GAIN_W-1:0]   ga_q, gb_q;
	logic signed [CUT_W-1:0]    cut_q;
	logic signed [CUT_W-1:0]    out_cut_q;
	logic signed [GAIN_W-1:0]   out_gain_q;
	logic                       out_side_q;

	logic                       in_a, in_b, same, eq;
	logic signed [GAIN_W:0]     w_g, d_a, d_b, sum_a, sum_b, neg_a;
	logic signed [GAIN_W-1:0]   new_ga, new_gb;
	logic                       new_sa;
	logic signed [CUT_W:0]      c_add, cut_sum;
	logic signed [CUT_W-1:0]    new_cut;
	logic                       wr_a_act, wr_b_act;

	assign in_a = 32'(a_q) < VERTICES;
	assign in_b = 32'(b_q) < VERTICES;
	assign same = a_q == b_q;
	assign eq   = sa_q == sb_q;

	assign w_g   = (GAIN_W+1)'(w_q);
	assign d_a   = eq ? w_g : -w_g;
	assign sum_a = (GAIN_W+1)'(ga_q) + d_a;
	assign neg_a = -((GAIN_W+1)'(ga_q));
	assign d_b   = (kind_q == KIND_NBR) ? (eq ? (w_g <<< 1) : -(w_g <<< 1)) : d_a;
	assign sum_b = (GAIN_W+1)'(gb_q) + d_b;
	assign new_gb = sat_gain(sum_b);

	always_comb begin
		new_ga  = ga_q;
		new_sa  = sa_q;
		new_cut = cut_q;
		c_add   = (CUT_W+1)'(w_q);
		case (kind_q)
			KIND_LOAD: begin
				new_ga  = '0;
				new_sa  = s_q;
				new_cut = '0;
			end
			KIND_EDGE: begin
				new_ga = sat_gain(sum_a);
				if (!eq) new_cut = sat_cut(cut_sum);
			end
			KIND_FLIP: begin
				new_ga  = sat_gain(neg_a);
				new_sa  = !sa_q;
				c_add   = (CUT_W+1)'(ga_q);
				new_cut = sat_cut(cut_sum);
			end
			default: new_cut = cut_q;
		endcase
	end

	assign cut_sum = (CUT_W+1)'(cut_q) + c_add;

	assign wr_a_act = cmd.wr_a && in_a && (kind_q != KIND_NBR);
	assign wr_b_act = cmd.wr_b && in_b && (kind_q == KIND_EDGE || kind_q == KIND_NBR);
	assign we       = wr_a_act || wr_b_act;
	assign wdata    = wr_a_act ? {new_sa, new_ga} : {sb_q, new_gb};

	always_comb begin
		if (cmd.accept) begin
			addr = AW'(vertex_a);
		end else if (cmd.cap_a || cmd.cap_b || cmd.wr_b) begin
			addr = AW'(b_q);
		end else begin
			addr = AW'(a_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind_t'(kind);
			a_q    <= vertex_a;
			b_q    <= vertex_b;
			w_q    <= edge_weight;
			s_q    <= side;
		end
		if (cmd.cap_a) begin
			sa_q <= in_a ? rdata_q[GAIN_W] : 1'b0;
			ga_q <= in_a ? rdata_q[GAIN_W-1:0] : '0;
		end
		if (cmd.cap_b) begin
			sb_q <= in_b ? rdata_q[GAIN_W] : 1'b0;
			gb_q <= in_b ? rdata_q[GAIN_W-1:0] : '0;
		end
		if (wr_a_act) begin
			sa_q <= new_sa;
			ga_q <= new_ga;
			if (same) begin
				sb_q <= new_sa;
				gb_q <= new_ga;
			end
		end
		if (wr_b_act) begin
			gb_q <= new_gb;
			if (same) ga_q <= new_gb;
		end
		if (cmd.load_out) begin
			out_cut_q  <= cut_q;
			out_gain_q <= ga_q;
			out_side_q <= sa_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q <= '0;
		end else if (cmd.wr_a) begin
			cut_q <= new_cut;
		end
	end

	assign cut_value   = out_cut_q;
	assign vertex_gain = out_gain_q;
	assign vertex_side = out_side_q;

endmodule

@@ src/max_cut_gain_tracker.sv @@
// Max-cut gain tracker: keeps a side bit and a saturating Q24.16 flip gain per
// vertex in one single-port memory, plus a saturating Q32.16 cut total that
// reset clears. Each input beat (load, edge, flip, neighbor update) returns
// one result beat with the cut and the side and gain of vertex_a after the
// update. Its result enters the output register once that is free, and a new
// beat is accepted only when the block is idle again: the single memory port
// does read a, read b, write a and write b one after another. The output
// register lets the next item start while a result waits. Vertex memory
// contents are undefined until loaded.
module max_cut_gain_tracker #(
	parameter int VERTICES = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [mcg_pkg::KIND_W-1:0]            kind,
	input  logic [mcg_pkg::VID_W-1:0]             vertex_a,
	input  logic [mcg_pkg::VID_W-1:0]             vertex_b,
	input  logic signed [mcg_pkg::WEIGHT_W-1:0]   edge_weight,
	input  logic                                  side,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [mcg_pkg::CUT_W-1:0]      cut_value,
	output logic signed [mcg_pkg::GAIN_W-1:0]     vertex_gain,
	output logic                                  vertex_side
);
	import mcg_pkg::*;

	cmd_t cmd;

	mcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mcg_datapath #(
		.VERTICES (VERTICES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.kind        (kind),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.edge_weight (edge_weight),
		.side        (side),
		.cut_value   (cut_value),
		.vertex_gain (vertex_gain),
		.vertex_side (vertex_side)
	);

endmodule

@@ tb/max_cut_gain_tracker_check.sv @@
module max_cut_gain_tracker_check
	import mcg_pkg::*;
#(
	parameter int VERTICES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [KIND_W-1:0]          kind,
	input  logic [VID_W-1:0]           vertex_a,
	input  logic [VID_W-1:0]           vertex_b,
	input  logic signed [WEIGHT_W-1:0] edge_weight,
	input  logic                       side,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [CUT_W-1:0]    cut_value,
	input  logic signed [GAIN_W-1:0]   vertex_gain,
	input  logic                       vertex_side,
	output int                         fail_count,
	output int                         pending
);

	localparam longint GAIN_HI = 64'sd549755813887;
	localparam longint GAIN_LO = -64'sd549755813888;
	localparam longint CUT_HI  = 64'sd140737488355327;
	localparam longint CUT_LO  = -64'sd140737488355328;

	typedef struct {
		logic signed [CUT_W-1:0]  cut;
		logic signed [GAIN_W-1:0] gain;
		logic                     side;
	} snapshot_t;

	logic                     side_mem [VERTICES];
	logic signed [GAIN_W-1:0] gain_mem [VERTICES];
	logic signed [CUT_W-1:0]  cut_acc;
	snapshot_t                snapshots_due [$];
	snapshot_t                want;
	int                       misses;

	assign fail_count = misses;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic side_of(input int v);
		return (v < VERTICES) ? side_mem[v] : 1'b0;
	endfunction

	function automatic longint gain_of(input int v);
		return (v < VERTICES) ? longint'(gain_mem[v]) : 0;
	endfunction

	function automatic void bump_gain(input int v, input longint d);
		if (v < VERTICES)
			gain_mem[v] = GAIN_W'(clip(gain_of(v) + d, GAIN_LO, GAIN_HI));
	endfunction

	function automatic void bump_cut(input longint d);
		cut_acc = CUT_W'(clip(longint'(cut_acc) + d, CUT_LO, CUT_HI));
	endfunction

	// updates the tracked tables for one beat and returns what the block must report
	function automatic snapshot_t track_item(input kind_t k, input int a, input int b,
			input longint w, input logic s);
		longint    g;
		longint    d;
		snapshot_t r;
		case (k)
			KIND_LOAD: begin
				if (a < VERTICES) begin
					side_mem[a] = s;
					gain_mem[a] = '0;
				end
				cut_acc = '0;
			end
			KIND_EDGE: begin
				if (side_of(a) == side_of(b)) begin
					bump_gain(a, w);
					bump_gain(b, w);
				end else begin
					bump_cut(w);
					bump_gain(a, -w);
					bump_gain(b, -w);
				end
			end
			KIND_FLIP: begin
				g = gain_of(a);
				bump_cut(g);
				if (a < VERTICES) begin
					side_mem[a] = !side_mem[a];
					gain_mem[a] = GAIN_W'(clip(-g, GAIN_LO, GAIN_HI));
				end
			end
			default: begin
				d = 2 * w;
				if (side_of(a) != side_of(b))
					d = -d;
				bump_gain(b, d);
			end
		endcase
		r.cut  = cut_acc;
		r.gain = GAIN_W'(gain_of(a));
		r.side = side_of(a);
		return r;
	endfunction

	function automatic void note_mismatch(input string field, input longint exp_v,
			input longint got_v);
		misses++;
		$display("%0t: %s expected %0d actual %0d", $time, field, exp_v, got_v);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_acc = '0;
			snapshots_due.delete();
			misses = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (snapshots_due.size() == 0) begin
					misses++;
					$display("%0t: result beat with nothing expected, actual cut %0d gain %0d side %0d",
						$time, cut_value, vertex_gain, vertex_side);
				end else begin
					want = snapshots_due.pop_front();
					if (cut_value !== want.cut)
						note_mismatch("cut_value", longint'(want.cut),
							longint'(cut_value));
					if (vertex_gain !== want.gain)
						note_mismatch("vertex_gain", longint'(want.gain),
							longint'(vertex_gain));
					if (vertex_side !== want.side)
						note_mismatch("vertex_side", longint'(want.side),
							longint'(vertex_side));
				end
			end
			if (in_valid && in_ready)
				snapshots_due.push_back(track_item(kind_t'(kind), int'(vertex_a),
					int'(vertex_b), longint'(edge_weight), side));
			pending <= snapshots_due.size();
		end
	end

endmodule

@@ tb/max_cut_gain_tracker_test.sv @@
module max_cut_gain_tracker_test;
	import mcg_pkg::*;

	localparam logic signed [WEIGHT_W-1:0] W_MAX = 24'sh7FFFFF;
	localparam logic signed [WEIGHT_W-1:0] W_MIN = 24'sh800000;
	localparam int RAMP_VERTEX = 512;
	localparam int RAMP_STEPS  = 16;
	localparam int RANDOM_ITEMS = 500;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [KIND_W-1:0]          kind;
	logic [VID_W-1:0]           vertex_a;
	logic [VID_W-1:0]           vertex_b;
	logic signed [WEIGHT_W-1:0] edge_weight;
	logic                       side;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [CUT_W-1:0]    cut_value;
	logic signed [GAIN_W-1:0]   vertex_gain;
	logic                       vertex_side;
	logic                       calm;
	int                         fail_count;
	int                         pending;

	bit is_loaded [1024];
	int loaded_ids [$];

	max_cut_gain_tracker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.edge_weight (edge_weight),
		.side        (side),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cut_value   (cut_value),
		.vertex_gain (vertex_gain),
		.vertex_side (vertex_side)
	);

	max_cut_gain_tracker_check chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.edge_weight (edge_weight),
		.side        (side),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cut_value   (cut_value),
		.vertex_gain (vertex_gain),
		.vertex_side (vertex_side),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 8);

	// called right after a rising edge; returns at the edge that takes the beat
	task automatic send_item(input kind_t k, input int a, input int b,
			input logic signed [WEIGHT_W-1:0] w, input logic s);
		if (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		vertex_a    <= VID_W'(a);
		vertex_b    <= VID_W'(b);
		edge_weight <= w;
		side        <= s;
		if (k == KIND_LOAD && !is_loaded[a]) begin
			is_loaded[a] = 1'b1;
			loaded_ids.push_back(a);
		end
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic int any_loaded();
		return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
	endfunction

	function automatic logic signed [WEIGHT_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return W_MAX;
			1: return W_MIN;
			2: return WEIGHT_W'($urandom_range(0, 511) - 256);
			default: return WEIGHT_W'($urandom);
		endcase
	endfunction

	initial begin
		int pick;
		int a;
		int b;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		kind        <= KIND_LOAD;
		vertex_a    <= '0;
		vertex_b    <= '0;
		edge_weight <= '0;
		side        <= 1'b0;
		out_ready   <= 1'b0;
		calm        <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(KIND_LOAD, 0, 1023, W_MAX, 1'b0);
		send_item(KIND_LOAD, 1023, 0, W_MIN, 1'b1);
		send_item(KIND_LOAD, 5, 7, 24'sd1, 1'b1);
		send_item(KIND_LOAD, 6, 9, -24'sd1, 1'b0);
		send_item(KIND_EDGE, 0, 1023, W_MAX, 1'b1);
		send_item(KIND_EDGE, 5, 1023, W_MIN, 1'b0);
		send_item(KIND_EDGE, 0, 6, 24'sh010000, 1'b0);
		send_item(KIND_EDGE, 6, 6, -24'sd3, 1'b1);
		send_item(KIND_EDGE, 5, 6, 24'sd12345, 1'b0);
		send_item(KIND_EDGE, 1023, 1023, W_MAX, 1'b0);
		send_item(KIND_EDGE, 0, 5, 24'sd0, 1'b1);
		send_item(KIND_FLIP, 0, 1023, W_MIN, 1'b1);
		send_item(KIND_FLIP, 1023, 0, W_MAX, 1'b0);
		send_item(KIND_NBR, 0, 1023, W_MAX, 1'b0);
		send_item(KIND_NBR, 1023, 0, W_MIN, 1'b1);
		send_item(KIND_NBR, 5, 5, 24'sd7, 1'b0);
		send_item(KIND_NBR, 6, 5, -24'sd100, 1'b1);
		send_item(KIND_FLIP, 5, 5, 24'sd0, 1'b0);
		send_item(KIND_LOAD, 0, 6, 24'sd5, 1'b1);
		send_item(KIND_FLIP, 6, 0, 24'sd0, 1'b1);
		send_item(KIND_NBR, 0, 6, 24'sd1, 1'b0);
		drain();

		// walk one gain down in large steps, then flip it and push it back
		send_item(KIND_LOAD, RAMP_VERTEX, 0, 24'sd0, 1'b0);
		repeat (RAMP_STEPS)
			send_item(KIND_NBR, RAMP_VERTEX, RAMP_VERTEX, W_MIN, 1'b0);
		send_item(KIND_FLIP, RAMP_VERTEX, 3, W_MAX, 1'b1);
		send_item(KIND_NBR, RAMP_VERTEX, RAMP_VERTEX, W_MAX, 1'b1);
		send_item(KIND_EDGE, RAMP_VERTEX, RAMP_VERTEX, W_MAX, 1'b0);
		send_item(KIND_FLIP, RAMP_VERTEX, 0, 24'sd0, 1'b0);
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= 200 && n < 300);
			pick = $urandom_range(0, 99);
			a = any_loaded();
			b = ($urandom_range(0, 7) == 0) ? a : any_loaded();
			if (pick < 10) begin
				a = ($urandom_range(0, 3) == 0) ? a : $urandom_range(0, 1023);
				send_item(KIND_LOAD, a, $urandom_range(0, 1023), pick_weight(),
					1'($urandom));
			end else if (pick < 45)
				send_item(KIND_EDGE, a, b, pick_weight(), 1'($urandom));
			else if (pick < 65)
				send_item(KIND_FLIP, a, $urandom_range(0, 1023), pick_weight(),
					1'($urandom));
			else
				send_item(KIND_NBR, a, b, pick_weight(), 1'($urandom));
		end
		drain();
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("[max_cut_gain_tracker] OK");
		else
			$display("[max_cut_gain_tracker] ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("[max_cut_gain_tracker] ERROR");
		$finish;
	end

endmodule
